// File: hdl/pb91_pkg.sv
package pb91_pkg;

    localparam int SYM_W       = 6;
    localparam int STORE_DEPTH = 13;
    localparam int ADDR_W      = 4;
    localparam int CHAR_W      = 7;
    localparam int VALUE_W     = 13;
    localparam int RADIX       = 91;
    localparam int DIV_MULT    = 5762;
    localparam int DIV_SHIFT   = 19;
    localparam int PROD_W      = 26;

    localparam logic [CHAR_W-1:0] CHAR_BASE = CHAR_W'(32);
    localparam logic [CHAR_W-1:0] MARK_A    = CHAR_W'((90 * 91 + 90) / 91 + 32);
    localparam logic [CHAR_W-1:0] MARK_B    = CHAR_W'((90 * 91 + 90) % 91 + 32);
    localparam logic [SYM_W-1:0]  TOP_SYM_BIT = SYM_W'(1 << (SYM_W - 1));
    localparam logic [2:0]        PAIRS_FULL  = 3'd6;

    localparam logic OP_DATA = 1'b0;
    localparam logic OP_END  = 1'b1;

    typedef struct packed {
        logic       operation;
        logic [7:0] data_byte;
    } in_beat_t;

    typedef struct packed {
        logic [CHAR_W-1:0] out_char;
        logic              last_of_run;
    } out_beat_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [SYM_W-1:0]  data;
    } store_wr_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PACK,
        ST_RD_HI,
        ST_RD_LO,
        ST_EMIT_HI,
        ST_EMIT_LO,
        ST_MARK_A,
        ST_MARK_B,
        ST_MARK_CNT
    } state_t;

    // Quotient by 91 through a reciprocal multiply, exact for all 13-bit values.
    function automatic logic [CHAR_W-1:0] div_radix(input logic [VALUE_W-1:0] v);
        logic [PROD_W-1:0] prod;
        prod = PROD_W'(v) * PROD_W'(DIV_MULT);
        return prod[DIV_SHIFT +: CHAR_W];
    endfunction

    function automatic logic [CHAR_W-1:0] rem_radix(input logic [VALUE_W-1:0] v,
                                                    input logic [CHAR_W-1:0] q);
        logic [VALUE_W-1:0] back;
        logic [VALUE_W-1:0] diff;
        back = VALUE_W'(q) * VALUE_W'(RADIX);
        diff = v - back;
        return diff[CHAR_W-1:0];
    endfunction

endpackage

// File: hdl/pb91_symstore.sv
module pb91_symstore (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  pb91_pkg::store_wr_t                 wr,
    input  logic [pb91_pkg::ADDR_W-1:0]         rd_addr,
    output logic [pb91_pkg::SYM_W-1:0]          rd_data,
    output logic [pb91_pkg::SYM_W-1:0]          top_data
);

    logic [pb91_pkg::SYM_W-1:0] mem_reg [pb91_pkg::STORE_DEPTH];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < pb91_pkg::STORE_DEPTH; i++) begin
                mem_reg[i] <= '0;
            end
        end else if (wr.en) begin
            mem_reg[wr.addr] <= wr.data;
        end
    end

    assign rd_data  = (rd_addr < pb91_pkg::ADDR_W'(pb91_pkg::STORE_DEPTH)) ?
                      mem_reg[rd_addr] : '0;
    assign top_data = mem_reg[pb91_pkg::STORE_DEPTH-1];

endmodule

// File: hdl/printable_base91_byte_encoder.sv
// Encodes raw bytes into printable characters (codes 32 to 122), one beat per byte or
// end-of-stream marker in, one character per beat out, with last_of_run on the final
// character an input beat causes. A data byte that does not complete a group of three
// is only held, and input stays ready. A completed group writes its four symbols into
// the 13-entry symbol store, one symbol per cycle. When the store is full, the group
// first finds it full in ST_PACK and fetches the first pair (ST_RD_HI, ST_RD_LO), then
// drains six values at one character per cycle while the output is taken. An
// end-of-stream beat packs four symbols (plus that drain when its group overflows the
// store), emits three marker characters, fetches the first pair and emits two characters
// per remaining symbol pair. Each value's quotient by 91 comes from a single shared
// reciprocal-multiply unit and its remainder from multiplying back and subtracting, one
// pair at a time. Input is held off until all characters of the current beat have been
// generated; the output register lets the next beat be accepted while the last character
// still waits.
module printable_base91_byte_encoder (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  pb91_pkg::in_beat_t    s_payload,
    output logic                  m_valid,
    input  logic                  m_ready,
    output pb91_pkg::out_beat_t   m_payload
);

    localparam int SW = pb91_pkg::SYM_W;
    localparam int CW = pb91_pkg::CHAR_W;
    localparam int VW = pb91_pkg::VALUE_W;
    localparam int AW = pb91_pkg::ADDR_W;

    pb91_pkg::state_t    state_reg, state_next;
    logic [7:0]          hold_reg [3];
    logic [7:0]          hold_next [3];
    logic [1:0]          pos_reg, pos_next;
    logic [AW-1:0]       count_reg, count_next;
    logic [1:0]          n_reg, n_next;
    logic [1:0]          j_reg, j_next;
    logic                final_reg, final_next;
    logic                dump_final_reg, dump_final_next;
    logic [2:0]          k_reg, k_next;
    logic [2:0]          npairs_reg, npairs_next;
    logic [SW-1:0]       spread_reg, spread_next;
    logic [SW-1:0]       hi_reg, hi_next;
    logic [VW-1:0]       v_reg, v_next;
    logic [CW-1:0]       q_reg, q_next;
    logic [CW-1:0]       r_reg, r_next;
    logic                out_valid_reg, out_valid_next;
    pb91_pkg::out_beat_t out_reg, out_next;

    pb91_pkg::store_wr_t wr;
    logic [AW-1:0]       rd_addr;
    logic [SW-1:0]       rd_data;
    logic [SW-1:0]       top_data;

    logic                slot_free;
    logic                emit;
    logic [CW-1:0]       emit_char;
    logic                emit_last;
    logic [1:0]          pos_idx;
    logic [SW-1:0]       sym;
    logic [VW-1:0]       v_load;
    logic [CW-1:0]       q_load;
    logic                last_pair;
    logic [2:0]          final_pairs;
    logic [SW-1:0]       final_spread;
    logic [1:0]          rd_off;

    pb91_symstore u_store (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr       (wr),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data),
        .top_data (top_data)
    );

    assign slot_free = !out_valid_reg || m_ready;
    assign pos_idx   = (pos_reg == 2'd3) ? 2'd0 : pos_reg;
    assign v_load    = {spread_reg[SW-1], hi_reg, rd_data};
    assign q_load    = pb91_pkg::div_radix(v_load);
    assign last_pair = (k_reg == npairs_reg - 3'd1);
    assign rd_addr   = {k_reg, 1'b0} + AW'(rd_off);

    assign final_pairs = (count_reg >= AW'(pb91_pkg::STORE_DEPTH)) ? pb91_pkg::PAIRS_FULL :
                         3'((5'(count_reg) + 5'd1) >> 1);
    assign final_spread = (count_reg >= AW'(pb91_pkg::STORE_DEPTH)) ? top_data :
                          (count_reg[0] ? pb91_pkg::TOP_SYM_BIT : '0);

    always_comb begin
        unique case (j_reg)
            2'd0: sym = hold_reg[0][7:2];
            2'd1: sym = {hold_reg[0][1:0], hold_reg[1][7:4]};
            2'd2: sym = {hold_reg[1][3:0], hold_reg[2][7:6]};
            2'd3: sym = (n_reg == 2'd3) ? hold_reg[2][5:0] : SW'(n_reg);
        endcase
    end

    always_comb begin
        unique case (state_reg)
            pb91_pkg::ST_RD_LO:   rd_off = 2'd1;
            pb91_pkg::ST_EMIT_HI: rd_off = 2'd2;
            pb91_pkg::ST_EMIT_LO: rd_off = 2'd3;
            default:              rd_off = 2'd0;
        endcase
    end

    always_comb begin
        state_next      = state_reg;
        hold_next       = hold_reg;
        pos_next        = pos_reg;
        count_next      = count_reg;
        n_next          = n_reg;
        j_next          = j_reg;
        final_next      = final_reg;
        dump_final_next = dump_final_reg;
        k_next          = k_reg;
        npairs_next     = npairs_reg;
        spread_next     = spread_reg;
        hi_next         = hi_reg;
        v_next          = v_reg;
        q_next          = q_reg;
        r_next          = r_reg;
        wr              = '0;
        emit            = 1'b0;
        emit_char       = q_reg;
        emit_last       = 1'b0;
        s_ready         = 1'b0;

        unique case (state_reg)
            pb91_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_payload.operation == pb91_pkg::OP_END) begin
                        n_next     = (pos_reg == 2'd3) ? 2'd2 : pos_reg;
                        final_next = 1'b1;
                        j_next     = 2'd0;
                        state_next = pb91_pkg::ST_PACK;
                    end else begin
                        hold_next[pos_idx] = s_payload.data_byte;
                        if (pos_idx == 2'd2) begin
                            pos_next   = 2'd0;
                            n_next     = 2'd3;
                            j_next     = 2'd0;
                            state_next = pb91_pkg::ST_PACK;
                        end else begin
                            pos_next = pos_idx + 2'd1;
                        end
                    end
                end
            end
            pb91_pkg::ST_PACK: begin
                if (count_reg == AW'(pb91_pkg::STORE_DEPTH)) begin
                    k_next          = '0;
                    npairs_next     = pb91_pkg::PAIRS_FULL;
                    spread_next     = top_data;
                    dump_final_next = 1'b0;
                    state_next      = pb91_pkg::ST_RD_HI;
                end else begin
                    wr.en      = 1'b1;
                    wr.addr    = count_reg;
                    wr.data    = sym;
                    count_next = count_reg + AW'(1);
                    j_next     = j_reg + 2'd1;
                    if (j_reg == 2'd3) begin
                        state_next = final_reg ? pb91_pkg::ST_MARK_A : pb91_pkg::ST_IDLE;
                    end
                end
            end
            pb91_pkg::ST_RD_HI: begin
                hi_next    = rd_data;
                state_next = pb91_pkg::ST_RD_LO;
            end
            pb91_pkg::ST_RD_LO: begin
                v_next     = v_load;
                q_next     = q_load;
                state_next = pb91_pkg::ST_EMIT_HI;
            end
            pb91_pkg::ST_EMIT_HI: begin
                if (slot_free) begin
                    emit        = 1'b1;
                    emit_char   = q_reg + pb91_pkg::CHAR_BASE;
                    r_next      = pb91_pkg::rem_radix(v_reg, q_reg);
                    hi_next     = rd_data;
                    spread_next = spread_reg << 1;
                    state_next  = pb91_pkg::ST_EMIT_LO;
                end
            end
            pb91_pkg::ST_EMIT_LO: begin
                if (slot_free) begin
                    emit      = 1'b1;
                    emit_char = r_reg + pb91_pkg::CHAR_BASE;
                    emit_last = last_pair && (dump_final_reg || !final_reg);
                    if (!last_pair) begin
                        v_next     = v_load;
                        q_next     = q_load;
                        k_next     = k_reg + 3'd1;
                        state_next = pb91_pkg::ST_EMIT_HI;
                    end else begin
                        count_next = '0;
                        if (dump_final_reg) begin
                            pos_next        = 2'd0;
                            final_next      = 1'b0;
                            dump_final_next = 1'b0;
                            state_next      = pb91_pkg::ST_IDLE;
                        end else begin
                            state_next = pb91_pkg::ST_PACK;
                        end
                    end
                end
            end
            pb91_pkg::ST_MARK_A: begin
                if (slot_free) begin
                    emit       = 1'b1;
                    emit_char  = pb91_pkg::MARK_A;
                    state_next = pb91_pkg::ST_MARK_B;
                end
            end
            pb91_pkg::ST_MARK_B: begin
                if (slot_free) begin
                    emit       = 1'b1;
                    emit_char  = pb91_pkg::MARK_B;
                    state_next = pb91_pkg::ST_MARK_CNT;
                end
            end
            pb91_pkg::ST_MARK_CNT: begin
                if (slot_free) begin
                    emit            = 1'b1;
                    emit_char       = CW'(count_reg) + pb91_pkg::CHAR_BASE;
                    emit_last       = (final_pairs == 3'd0);
                    k_next          = '0;
                    npairs_next     = final_pairs;
                    spread_next     = final_spread;
                    dump_final_next = 1'b1;
                    if (final_pairs == 3'd0) begin
                        count_next      = '0;
                        pos_next        = 2'd0;
                        final_next      = 1'b0;
                        dump_final_next = 1'b0;
                        state_next      = pb91_pkg::ST_IDLE;
                    end else begin
                        state_next = pb91_pkg::ST_RD_HI;
                    end
                end
            end
            default: begin
                state_next = pb91_pkg::ST_IDLE;
            end
        endcase

        if (emit) begin
            out_valid_next       = 1'b1;
            out_next.out_char    = emit_char;
            out_next.last_of_run = emit_last;
        end else begin
            out_valid_next = out_valid_reg && !m_ready;
            out_next       = out_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= pb91_pkg::ST_IDLE;
            hold_reg[0]    <= '0;
            hold_reg[1]    <= '0;
            hold_reg[2]    <= '0;
            pos_reg        <= '0;
            count_reg      <= '0;
            final_reg      <= 1'b0;
            dump_final_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            hold_reg       <= hold_next;
            pos_reg        <= pos_next;
            count_reg      <= count_next;
            final_reg      <= final_next;
            dump_final_reg <= dump_final_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        n_reg      <= n_next;
        j_reg      <= j_next;
        k_reg      <= k_next;
        npairs_reg <= npairs_next;
        spread_reg <= spread_next;
        hi_reg     <= hi_next;
        v_reg      <= v_next;
        q_reg      <= q_next;
        r_reg      <= r_next;
        out_reg    <= out_next;
    end

    assign m_valid   = out_valid_reg;
    assign m_payload = out_reg;

endmodule

// File: hdl/pb91_checker.sv
module pb91_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input pb91_pkg::in_beat_t  s_payload,
    input logic                m_valid,
    input logic                m_ready,
    input pb91_pkg::out_beat_t m_payload
);

    // A stalled output beat keeps its character.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_payload))
        else $error("output beat changed while stalled");

    // Every character is printable.
    a_out_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_payload.out_char >= 7'd32 && m_payload.out_char <= 7'd122)
        else $error("output character out of printable range");

    // An end-of-stream beat always starts a flush, so input is held off next cycle.
    a_end_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_payload.operation == pb91_pkg::OP_END |=> !s_ready)
        else $error("input accepted right after end of stream");

    // Reset leaves no output beat pending.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid after reset");

endmodule

bind printable_base91_byte_encoder pb91_checker u_pb91_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .s_payload (s_payload),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_payload (m_payload)
);
